/* hdl/pgrs_pkg.sv */
// Shared constants, codes and helpers for the grid relaxation solver.
`default_nettype none
package pgrs_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 64;

    // shared multiplier operand widths
    localparam int MUL_A_W = VALUE_WIDTH;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] METHOD_JACOBI = 2'd0;
    localparam logic [1:0] METHOD_SEIDEL = 2'd1;

    localparam logic [2:0] CFG_METHOD  = 3'd0;
    localparam logic [2:0] CFG_OMEGA   = 3'd1;
    localparam logic [2:0] CFG_H2      = 3'd2;
    localparam logic [2:0] CFG_TOL     = 3'd3;
    localparam logic [2:0] CFG_LIMIT   = 3'd4;
    localparam logic [2:0] CFG_ROWS    = 3'd5;
    localparam logic [2:0] CFG_COLS    = 3'd6;

    localparam logic [1:0]  RST_METHOD = 2'd2;
    localparam logic [14:0] RST_OMEGA  = 15'd24576;
    localparam logic [23:0] RST_H2     = 24'd6988;
    localparam logic [30:0] RST_TOL    = 31'd17;
    localparam logic [15:0] RST_LIMIT  = 16'd10000;
    localparam logic [6:0]  RST_DIM    = 7'd50;

    localparam logic signed [MUL_B_W-1:0] Q14_ONE = 25'sd16384;

    // clamp to the signed value range
    function automatic logic [VALUE_WIDTH-1:0] sat_val(input logic signed [63:0] v);
        logic signed [63:0] vmax;
        logic signed [63:0] vmin;
        vmax = (64'sd1 <<< (VALUE_WIDTH - 1)) - 64'sd1;
        vmin = -vmax - 64'sd1;
        if (v > vmax) begin
            return vmax[VALUE_WIDTH-1:0];
        end else if (v < vmin) begin
            return vmin[VALUE_WIDTH-1:0];
        end
        return v[VALUE_WIDTH-1:0];
    endfunction

endpackage
`default_nettype wire

/* hdl/poisson_grid_relaxation_solver_core.sv */
// Top level: grid stores, stencil sequencer and result register of the solver.
//
//  channel | ports                         | carries
//  --------+-------------------------------+------------------------------------
//  s_      | s_tvalid/s_tready/s_tdata/tuser| write, solve or read item
//  m_      | m_tvalid/m_tready/m_tdata/tuser| read data or solve status
//  cfg_    | cfg_valid/cfg_ready/index/data | register writes, always ready
//
// After reset a clearing pass zeroes the potential and source stores, one cell a
// cycle, all GRID_ROWS*GRID_COLS (4096 by default); no item is taken meanwhile.
// A write ends in S_IDLE; a read passes S_RDW, then waits in S_EMIT for the output register.
// Per sweep of a solve, each interior cell passes read, stencil and write states
// (Gauss-Seidel), plus blend states (SOR, the shared multiplier used three times)
// or a copy-back (Jacobi), each cell bound by the single potential read port.
// s_tready is low while an item is in work; a waiting result stalls the block.
`default_nettype none
module poisson_grid_relaxation_solver_core
    import pgrs_pkg::*;
#(
    parameter int GRID_ROWS = GRID_ROWS_DEF,
    parameter int GRID_COLS = GRID_COLS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row[5:0], col[11:6], potential_in[43:12], source_in[75:44]
    input  wire logic [79:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // potential_out[31:0], converged[32], sweeps_done[48:33], final_change[79:49]
    output logic [79:0]      m_tdata,
    // result_kind[0]
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CW    = $clog2(GRID_COLS);

    typedef enum logic [19:0] {
        S_CLEAR = 20'h00001, S_IDLE  = 20'h00002, S_RDW   = 20'h00004,
        S_EMIT  = 20'h00008, S_A0    = 20'h00010, S_A1    = 20'h00020,
        S_A2    = 20'h00040, S_A3    = 20'h00080, S_A4    = 20'h00100,
        S_A5    = 20'h00200, S_GS    = 20'h00400, S_M1    = 20'h00800,
        S_M2    = 20'h01000, S_M3    = 20'h02000, S_M4    = 20'h04000,
        S_WR    = 20'h08000, S_CP_RD = 20'h10000, S_CP_WR = 20'h20000,
        S_CHK   = 20'h40000, S_SPARE = 20'h80000
    } state_t;

    function automatic logic [AW-1:0] cell_addr(input logic [8:0] r, input logic [8:0] c);
        return AW'(int'(r) * GRID_COLS + int'(c));
    endfunction

    state_t state_reg, state_next;

    // configuration
    logic [1:0]  method_reg;
    logic [14:0] omega_reg;
    logic [23:0] h2_reg;
    logic [30:0] tol_reg;
    logic [15:0] limit_reg;
    logic [6:0]  rows_reg, cols_reg;

    // stores
    logic [VALUE_WIDTH-1:0] pot_mem [CELLS];
    logic [VALUE_WIDTH-1:0] src_mem [CELLS];
    logic [VALUE_WIDTH-1:0] sh_mem  [CELLS];
    logic [VALUE_WIDTH-1:0] pot_rd_reg, src_rd_reg, sh_rd_reg;
    logic                   pot_we, sh_we;
    logic [AW-1:0]          pot_waddr, pot_raddr, cur_addr;
    logic [VALUE_WIDTH-1:0] pot_wdata, src_wdata;

    // sequencer state
    logic [AW-1:0] clr_reg;
    logic [RW-1:0] r_reg;
    logic [CW-1:0] c_reg;
    logic [15:0]   sweep_cnt_reg;
    logic [30:0]   worst_reg;
    logic          conv_reg, kind_reg, inside_reg;
    logic signed [VALUE_WIDTH-1:0] old_reg, gs_reg, nv_reg, res_pot_reg;
    logic signed [VALUE_WIDTH+1:0] sum_reg;
    logic signed [MUL_P_W:0]       blend_reg;

    // shared multiplier
    logic                      mul_load;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;

    pgrs_mul u_mul (
        .aclk (aclk),
        .load (mul_load),
        .a_in (mul_a),
        .b_in (mul_b),
        .prod (prod)
    );

    // output register
    logic        m_tvalid_reg, m_tuser_reg;
    logic [79:0] m_tdata_reg;

    // input fields
    logic [1:0]             in_op;
    logic [5:0]             in_row, in_col;
    logic [VALUE_WIDTH-1:0] in_pot, in_src;
    logic                   in_inside, accept;
    assign in_op  = s_tuser;
    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_pot = s_tdata[43:12];
    assign in_src = s_tdata[75:44];
    assign in_inside = (9'(in_row) < 9'(GRID_ROWS)) && (9'(in_col) < 9'(GRID_COLS));
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // used grid size, clamped
    logic [8:0] rows_eff, cols_eff;
    always_comb begin
        rows_eff = (rows_reg < 7'd3) ? 9'd3 :
                   ((9'(rows_reg) > 9'(GRID_ROWS)) ? 9'(GRID_ROWS) : 9'(rows_reg));
        cols_eff = (cols_reg < 7'd3) ? 9'd3 :
                   ((9'(cols_reg) > 9'(GRID_COLS)) ? 9'(GRID_COLS) : 9'(cols_reg));
    end

    logic jacobi, sor, last_c, last_cell;
    assign jacobi    = (method_reg == METHOD_JACOBI);
    assign sor       = !jacobi && (method_reg != METHOD_SEIDEL);
    assign last_c    = (9'(c_reg) + 9'd2 == cols_eff);
    assign last_cell = last_c && (9'(r_reg) + 9'd2 == rows_eff);
    assign cur_addr  = cell_addr(9'(r_reg), 9'(c_reg));

    // stencil and blend arithmetic
    logic signed [VALUE_WIDTH+3:0] st_diff;
    logic signed [VALUE_WIDTH-1:0] gs_val, blend_val;
    logic signed [MUL_P_W:0]       blend_sum;
    logic signed [VALUE_WIDTH:0]   nv_diff;
    logic [VALUE_WIDTH:0]          nv_abs;
    logic [30:0]                   change;
    always_comb begin
        st_diff   = (VALUE_WIDTH+4)'(sum_reg) - (VALUE_WIDTH+4)'($signed(prod[MUL_P_W-1:24]));
        gs_val    = sat_val(64'($signed(st_diff[VALUE_WIDTH+3:2])));
        blend_sum = blend_reg + (MUL_P_W+1)'(prod);
        blend_val = sat_val(64'($signed(blend_sum[MUL_P_W:14])));
        nv_diff   = (VALUE_WIDTH+1)'(nv_reg) - (VALUE_WIDTH+1)'(old_reg);
        nv_abs    = nv_diff[VALUE_WIDTH] ? (VALUE_WIDTH+1)'(-nv_diff) : nv_diff;
        change    = (nv_abs > (VALUE_WIDTH+1)'(31'h7FFFFFFF)) ? 31'h7FFFFFFF : 31'(nv_abs);
    end

    // multiplier operand select
    always_comb begin
        mul_load = 1'b0;
        mul_a    = $signed(src_rd_reg);
        mul_b    = $signed({1'b0, h2_reg});
        unique case (state_reg)
            S_A1: mul_load = 1'b1;
            S_GS: begin
                mul_load = sor;
                mul_a    = old_reg;
                mul_b    = Q14_ONE - $signed({10'b0, omega_reg});
            end
            S_M2: begin
                mul_load = 1'b1;
                mul_a    = gs_reg;
                mul_b    = $signed({10'b0, omega_reg});
            end
            default: mul_load = 1'b0;
        endcase
    end

    // store ports
    always_comb begin
        pot_we    = 1'b0;
        sh_we     = 1'b0;
        pot_waddr = cur_addr;
        pot_wdata = nv_reg;
        src_wdata = '0;
        pot_raddr = cur_addr;
        unique case (state_reg)
            S_CLEAR: begin
                pot_we    = 1'b1;
                pot_waddr = clr_reg;
                pot_wdata = '0;
            end
            S_IDLE: begin
                pot_we    = accept && (in_op == OP_WRITE) && in_inside;
                pot_waddr = cell_addr(9'(in_row), 9'(in_col));
                pot_wdata = sat_val(64'($signed(in_pot)));
                src_wdata = sat_val(64'($signed(in_src)));
                pot_raddr = pot_waddr;
            end
            S_A1: pot_raddr = cell_addr(9'(r_reg) - 9'd1, 9'(c_reg));
            S_A2: pot_raddr = cell_addr(9'(r_reg) + 9'd1, 9'(c_reg));
            S_A3: pot_raddr = cell_addr(9'(r_reg), 9'(c_reg) - 9'd1);
            S_A4: pot_raddr = cell_addr(9'(r_reg), 9'(c_reg) + 9'd1);
            S_WR: begin
                pot_we = !jacobi;
                sh_we  = jacobi;
            end
            S_CP_WR: begin
                pot_we    = 1'b1;
                pot_wdata = sh_rd_reg;
            end
            default: pot_we = 1'b0;
        endcase
    end

    // source store is written only by the clearing pass and write items
    always_ff @(posedge aclk) begin
        if (pot_we) begin
            pot_mem[pot_waddr] <= pot_wdata;
        end
        pot_rd_reg <= pot_mem[pot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (pot_we && (state_reg == S_CLEAR || state_reg == S_IDLE)) begin
            src_mem[pot_waddr] <= src_wdata;
        end
        src_rd_reg <= src_mem[pot_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sh_we) begin
            sh_mem[cur_addr] <= nv_reg;
        end
        sh_rd_reg <= sh_mem[cur_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: if (clr_reg == AW'(CELLS - 1)) state_next = S_IDLE;
            S_IDLE: begin
                if (accept && in_op == OP_READ) begin
                    state_next = S_RDW;
                end else if (accept && in_op == OP_SOLVE) begin
                    state_next = (limit_reg == 16'd0) ? S_EMIT : S_A0;
                end
            end
            S_RDW:   state_next = S_EMIT;
            S_EMIT:  if (!m_tvalid_reg || m_tready) state_next = S_IDLE;
            S_A0:    state_next = S_A1;
            S_A1:    state_next = S_A2;
            S_A2:    state_next = S_A3;
            S_A3:    state_next = S_A4;
            S_A4:    state_next = S_A5;
            S_A5:    state_next = S_GS;
            S_GS:    state_next = sor ? S_M1 : S_WR;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_WR;
            S_WR: begin
                if (!last_cell) begin
                    state_next = S_A0;
                end else begin
                    state_next = jacobi ? S_CP_RD : S_CHK;
                end
            end
            S_CP_RD: state_next = S_CP_WR;
            S_CP_WR: state_next = last_cell ? S_CHK : S_CP_RD;
            S_CHK: begin
                if (worst_reg < tol_reg || sweep_cnt_reg + 16'd1 == limit_reg) begin
                    state_next = S_EMIT;
                end else begin
                    state_next = S_A0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            method_reg   <= RST_METHOD;
            omega_reg    <= RST_OMEGA;
            h2_reg       <= RST_H2;
            tol_reg      <= RST_TOL;
            limit_reg    <= RST_LIMIT;
            rows_reg     <= RST_DIM;
            cols_reg     <= RST_DIM;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (state_reg == S_EMIT && (!m_tvalid_reg || m_tready)) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_METHOD: method_reg <= cfg_data[1:0];
                    CFG_OMEGA:  omega_reg  <= cfg_data[14:0];
                    CFG_H2:     h2_reg     <= cfg_data[23:0];
                    CFG_TOL:    tol_reg    <= cfg_data[30:0];
                    CFG_LIMIT:  limit_reg  <= cfg_data[15:0];
                    CFG_ROWS:   rows_reg   <= cfg_data[6:0];
                    CFG_COLS:   cols_reg   <= cfg_data[6:0];
                    default:    ;
                endcase
            end
        end
    end

    // datapath and result holding registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                inside_reg <= in_inside;
                kind_reg   <= (in_op == OP_SOLVE);
                res_pot_reg   <= '0;
                sweep_cnt_reg <= '0;
                worst_reg     <= '0;
                conv_reg      <= 1'b0;
                r_reg         <= RW'(1);
                c_reg         <= CW'(1);
            end
            S_RDW: res_pot_reg <= inside_reg ? $signed(pot_rd_reg) : '0;
            S_A1:  old_reg <= $signed(pot_rd_reg);
            S_A2:  sum_reg <= (VALUE_WIDTH+2)'($signed(pot_rd_reg));
            S_A3, S_A4, S_A5: begin
                sum_reg <= sum_reg + (VALUE_WIDTH+2)'($signed(pot_rd_reg));
            end
            S_GS: begin
                gs_reg <= gs_val;
                nv_reg <= gs_val;
            end
            S_M2:  blend_reg <= (MUL_P_W+1)'(prod);
            S_M4:  nv_reg <= blend_val;
            S_WR, S_CP_WR: begin
                if (state_reg == S_WR && change > worst_reg) begin
                    worst_reg <= change;
                end
                if (last_cell) begin
                    r_reg <= RW'(1);
                    c_reg <= CW'(1);
                end else if (last_c) begin
                    r_reg <= r_reg + RW'(1);
                    c_reg <= CW'(1);
                end else begin
                    c_reg <= c_reg + CW'(1);
                end
            end
            S_CHK: begin
                sweep_cnt_reg <= sweep_cnt_reg + 16'd1;
                conv_reg      <= (worst_reg < tol_reg);
                if (!(worst_reg < tol_reg) && sweep_cnt_reg + 16'd1 != limit_reg) begin
                    worst_reg <= '0;
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tuser_reg <= kind_reg;
                    m_tdata_reg <= kind_reg ?
                        {worst_reg, sweep_cnt_reg, conv_reg, 32'd0} :
                        {48'd0, res_pot_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // no result while the stores are being cleared
    a_clear_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !m_tvalid_reg)
        else $error("result valid during clearing pass");

    // a solve holds off the input the next cycle
    a_solve_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_op == OP_SOLVE) |=> !s_tready)
        else $error("input ready right after solve accepted");

    // results come only out of the emit state
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    // a sweep never runs past the limit
    a_sweep_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR) |-> (sweep_cnt_reg < limit_reg))
        else $error("sweep beyond limit");

endmodule
`default_nettype wire

/* hdl/pgrs_mul.sv */
// Shared signed multiplier with registered operands and product.
`default_nettype none
module pgrs_mul
    import pgrs_pkg::*;
(
    input  wire logic                      aclk,
    input  wire logic                      load,
    input  wire logic signed [MUL_A_W-1:0] a_in,
    input  wire logic signed [MUL_B_W-1:0] b_in,
    output logic signed [MUL_P_W-1:0]      prod
);

    logic signed [MUL_A_W-1:0] a_reg;
    logic signed [MUL_B_W-1:0] b_reg;
    logic signed [MUL_P_W-1:0] prod_reg;

    // operands are captured on load, and the product is registered from them
    always_ff @(posedge aclk) begin
        if (load) begin
            a_reg <= a_in;
            b_reg <= b_in;
        end
        prod_reg <= MUL_P_W'(a_reg) * MUL_P_W'(b_reg);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

/* tb/tb_poisson_grid_relaxation_solver_core.sv */
// Self-checking testbench for the grid relaxation solver core.
`timescale 1ns / 1ps
`default_nettype none
module tb_poisson_grid_relaxation_solver_core;
    import pgrs_pkg::*;

    localparam int ROWS_MAX = 64;
    localparam int COLS_MAX = 64;
    localparam int CELLS    = ROWS_MAX * COLS_MAX;
    localparam logic [1:0] OP_NONE = 2'd3;    // unused op code, ignored by the block
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    // one result transfer: read data or solve status
    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        conv;
        logic [15:0] sweeps;
        logic [30:0] change;
    } outcome_t;

    // keeps a copy of the grid and registers, predicts each result
    class grid_scoreboard;
        longint      pot[CELLS];
        longint      srcv[CELLS];
        longint      shd[CELLS];
        logic [1:0]  method;
        logic [14:0] omega;
        logic [23:0] h2;
        logic [30:0] tol;
        logic [15:0] limit;
        logic [6:0]  rows;
        logic [6:0]  cols;
        outcome_t    pending[$];
        int          errors;

        function new();
            foreach (pot[i]) begin
                pot[i] = 0; srcv[i] = 0; shd[i] = 0;
            end
            method = RST_METHOD; omega = RST_OMEGA; h2 = RST_H2; tol = RST_TOL;
            limit = RST_LIMIT; rows = RST_DIM; cols = RST_DIM;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [30:0] data);
            case (idx)
                CFG_METHOD: method = data[1:0];
                CFG_OMEGA:  omega  = data[14:0];
                CFG_H2:     h2     = data[23:0];
                CFG_TOL:    tol    = data;
                CFG_LIMIT:  limit  = data[15:0];
                CFG_ROWS:   rows   = data[6:0];
                CFG_COLS:   cols   = data[6:0];
                default: ;
            endcase
        endfunction

        function longint clampv(longint v);
            if (v > VMAX) return VMAX;
            if (v < VMIN) return VMIN;
            return v;
        endfunction

        function int used_dim(logic [6:0] v, int hi);
            if (v < 3) return 3;
            if (v > hi) return hi;
            return v;
        endfunction

        // one pass over the interior, returns the largest change
        function longint relax_pass();
            int r, c, idx, nr, nc;
            longint acc, term, gs, nv, d, worst;
            worst = 0;
            nr = used_dim(rows, ROWS_MAX);
            nc = used_dim(cols, COLS_MAX);
            for (r = 1; r + 1 < nr; r++) begin
                for (c = 1; c + 1 < nc; c++) begin
                    idx  = r * COLS_MAX + c;
                    acc  = pot[idx - COLS_MAX] + pot[idx + COLS_MAX] + pot[idx - 1] + pot[idx + 1];
                    term = (srcv[idx] * longint'(h2)) >>> 24;
                    gs   = clampv((acc - term) >>> 2);
                    if (method == METHOD_JACOBI || method == METHOD_SEIDEL) begin
                        nv = gs;
                    end else begin
                        nv = clampv((pot[idx] * (16384 - longint'(omega))
                                     + gs * longint'(omega)) >>> 14);
                    end
                    d = nv - pot[idx];
                    if (d < 0) d = -d;
                    if (d > VMAX) d = VMAX;
                    if (d > worst) worst = d;
                    if (method == METHOD_JACOBI) shd[idx] = nv;
                    else pot[idx] = nv;
                end
            end
            if (method == METHOD_JACOBI) begin
                for (r = 1; r + 1 < nr; r++)
                    for (c = 1; c + 1 < nc; c++)
                        pot[r * COLS_MAX + c] = shd[r * COLS_MAX + c];
            end
            return worst;
        endfunction

        function void note_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                                logic [31:0] pin, logic [31:0] sin);
            outcome_t o;
            int      idx;
            longint  worst;
            int      done;
            idx = row * COLS_MAX + col;
            o = '0;
            case (op)
                OP_WRITE: begin
                    pot[idx]  = longint'(signed'(pin));
                    srcv[idx] = longint'(signed'(sin));
                end
                OP_READ: begin
                    o.value = pot[idx][31:0];
                    pending.push_back(o);
                end
                OP_SOLVE: begin
                    worst = 0;
                    done = 0;
                    while (done < limit) begin
                        worst = relax_pass();
                        done++;
                        if (worst < longint'(tol)) begin
                            o.conv = 1'b1;
                            break;
                        end
                    end
                    o.kind   = 1'b1;
                    o.sweeps = done[15:0];
                    o.change = worst[30:0];
                    pending.push_back(o);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic kind, logic [79:0] data);
            outcome_t got, want;
            got = '{kind, data[31:0], data[32], data[48:33], data[79:49]};
            if (pending.size() == 0) begin
                $display("%0t: unexpected result kind=%0d data=%h", $realtime, kind, data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind)
                $display("%0t: result_kind expected %0d actual %0d", $realtime, want.kind, got.kind);
            if (got.value !== want.value)
                $display("%0t: potential_out expected %h actual %h", $realtime, want.value, got.value);
            if (got.conv !== want.conv)
                $display("%0t: converged expected %0d actual %0d", $realtime, want.conv, got.conv);
            if (got.sweeps !== want.sweeps)
                $display("%0t: sweeps_done expected %0d actual %0d",
                         $realtime, want.sweeps, got.sweeps);
            if (got.change !== want.change)
                $display("%0t: final_change expected %h actual %h",
                         $realtime, want.change, got.change);
            if (got !== want) errors++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [1:0]  s_tuser = OP_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [30:0] cfg_data = '0;

    grid_scoreboard grid_sb = new();
    int send_idle_pct = 0;     // chance of a gap before each input transfer
    int recv_idle_pct = 0;     // chance m_tready is low in a cycle

    poisson_grid_relaxation_solver_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) grid_sb.check_result(m_tuser, m_tdata);
    end

    // hard stop well past the slowest legal run
    initial begin
        #50_000_000;
        $display("tb_poisson_grid_relaxation_solver_core NOT OK");
        $finish;
    end

    task automatic send_item(logic [1:0] op, logic [5:0] row, logic [5:0] col,
                             logic [31:0] pin, logic [31:0] sin);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {4'b0, sin, pin, col, row};
        do @(posedge aclk); while (!s_tready);
        grid_sb.note_item(op, row, col, pin, sin);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [30:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge aclk); while (!cfg_ready);
        grid_sb.set_reg(idx, data);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // let every expected transfer drain, then a short pause for trailing writes
    task automatic drain();
        while (grid_sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic setup(logic [1:0] meth, logic [14:0] om, logic [23:0] hh, logic [30:0] tl,
                         logic [15:0] lim, logic [6:0] nr, logic [6:0] nc);
        write_reg(CFG_METHOD, 31'(meth));
        write_reg(CFG_OMEGA, 31'(om));
        write_reg(CFG_H2, 31'(hh));
        write_reg(CFG_TOL, tl);
        write_reg(CFG_LIMIT, 31'(lim));
        write_reg(CFG_ROWS, 31'(nr));
        write_reg(CFG_COLS, 31'(nc));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int nr, nc, count;
        logic [5:0] r, c;

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed: one interior cell, Gauss-Seidel, full sweep budget
        setup(METHOD_SEIDEL, RST_OMEGA, RST_H2, 31'd1, 16'hFFFF, 7'd3, 7'd3);
        send_item(OP_WRITE, 6'd0, 6'd1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(OP_WRITE, 6'd2, 6'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_WRITE, 6'd1, 6'd0, 32'h7FFF_FFFF, 32'h0);
        send_item(OP_WRITE, 6'd1, 6'd1, 32'h0, 32'h7FFF_FFFF);
        send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0, 32'h0);
        send_item(OP_READ, 6'd1, 6'd1, 32'h0, 32'h0);
        send_item(OP_NONE, 6'd1, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_READ, 6'd63, 6'd63, 32'h0, 32'h0);
        send_item(OP_WRITE, 6'd63, 6'd63, 32'h8000_0000, 32'h8000_0000);
        drain();
        // full grid, Jacobi, one sweep
        setup(METHOD_JACOBI, 15'd0, 24'hFF_FFFF, 31'h7FFF_FFFF, 16'd1, 7'd64, 7'd64);
        send_item(OP_WRITE, 6'd62, 6'd62, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0, 32'h0);
        send_item(OP_READ, 6'd62, 6'd62, 32'h0, 32'h0);
        drain();
        // clamped sizes, unused method, zero sweep limit, zero tolerance
        setup(2'd3, 15'h7FFF, 24'hFF_FFFF, 31'd0, 16'd0, 7'd0, 7'd127);
        send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0, 32'h0);
        drain();
        write_reg(CFG_LIMIT, 31'd3);
        send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0, 32'h0);
        send_item(OP_READ, 6'd1, 6'd5, 32'h0, 32'h0);
        drain();
        setup(2'd2, 15'd0, 24'd0, 31'd1000, 16'd2, 7'd127, 7'd2);
        send_item(OP_SOLVE, 6'd0, 6'd0, 32'h0, 32'h0);
        send_item(OP_READ, 6'd62, 6'd1, 32'h0, 32'h0);
        drain();

        // random: load a grid, solve it, read some cells back
        count = 0;
        for (int phase = 0; phase < 12; phase++) begin
            if (phase < 4) begin
                send_idle_pct = 20; recv_idle_pct = 79;
            end else if (phase < 8) begin
                send_idle_pct = 79; recv_idle_pct = 20;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            setup(2'($urandom_range(0, 3)), 15'($urandom), 24'($urandom),
                  ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                  ($urandom_range(0, 4) == 0) ? 31'd0 : 31'($urandom_range(1, 4000)),
                  ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 12)),
                  7'($urandom_range(0, 8)), 7'($urandom_range(0, 8)));
            nr = grid_sb.used_dim(grid_sb.rows, ROWS_MAX);
            nc = grid_sb.used_dim(grid_sb.cols, COLS_MAX);
            for (int b = 0; b < 5; b++) begin
                repeat ($urandom_range(3, 10)) begin
                    if ($urandom_range(0, 9) == 0) begin
                        r = 6'($urandom); c = 6'($urandom);
                    end else begin
                        r = 6'($urandom_range(0, nr - 1)); c = 6'($urandom_range(0, nc - 1));
                    end
                    send_item(($urandom_range(0, 19) == 0) ? OP_NONE : OP_WRITE,
                              r, c, pick_value(), pick_value());
                    count++;
                end
                send_item(OP_SOLVE, 6'($urandom), 6'($urandom), $urandom, $urandom);
                repeat ($urandom_range(1, 4)) begin
                    send_item(OP_READ, 6'($urandom_range(0, nr - 1)),
                              6'($urandom_range(0, nc - 1)), $urandom, $urandom);
                    count++;
                end
                if (phase == 5 && b == 1) drain();   // sender holds until all results are in
            end
            drain();
        end

        while (grid_sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (grid_sb.errors == 0 && grid_sb.pending.size() == 0) begin
            $display("tb_poisson_grid_relaxation_solver_core OK");
        end else begin
            $display("tb_poisson_grid_relaxation_solver_core NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
